@@ sv/rx_completion_ring_consumer_top_macros.svh @@
// ----------------------------------------------------------------------------
// rx_completion_ring_consumer_top_macros
// Assertion macros shared by the completion ring consumer.
// ----------------------------------------------------------------------------
`ifndef RX_COMPLETION_RING_CONSUMER_TOP_MACROS_SVH
`define RX_COMPLETION_RING_CONSUMER_TOP_MACROS_SVH

// Check a consequence in the same cycle as its antecedent
`define RXCRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rxcrc same-cycle check failed");

// Check a consequence in the cycle after its antecedent
`define RXCRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rxcrc next-cycle check failed");

`endif

@@ sv/rxcrc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxcrc_pkg
// Types and constants of the receive completion ring consumer.
// ----------------------------------------------------------------------------
package rxcrc_pkg;

    localparam int IDX_W = 7;
    localparam int QID_W = 10;
    localparam int LEN_W = 14;

    localparam logic [LEN_W-1:0] MIN_LEN_RESET = 14'd60;

    typedef enum logic [1:0] {
        DROP_NONE  = 2'd0,
        DROP_BODY  = 2'd1,
        DROP_ERROR = 2'd2,
        DROP_SHORT = 2'd3
    } t_drop_reason;

    // One completion descriptor
    typedef struct packed {
        logic [IDX_W-1:0] buffer_index;
        logic [QID_W-1:0] queue_id;
        logic [LEN_W-1:0] frame_len_in;
        logic             error_bit;
        logic             gen_bit;
        logic             buffer_kind;
        logic             head_update_asked;
    } t_comp_item;

    // One result
    typedef struct packed {
        logic             stale;
        t_drop_reason     drop_reason;
        logic             ring_select;
        logic [IDX_W-1:0] slot_out;
        logic [LEN_W-1:0] frame_len_out;
        logic             head_write;
        logic             head_bank;
        logic [QID_W-1:0] head_queue;
        logic [IDX_W-1:0] head_value;
        logic [IDX_W-1:0] refill_slot;
        logic             refill_gen;
    } t_result;

    // Pointer state seen by the classify logic
    typedef struct packed {
        logic             exp_gen;
        logic [IDX_W-1:0] refill_slot;
        logic             refill_gen;
    } t_ptr_state;

endpackage

@@ sv/rxcrc_comp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxcrc_comp_if
// Valid/ready channel carrying one receive completion descriptor.
// ----------------------------------------------------------------------------
interface rxcrc_comp_if;
    logic                            valid;
    logic                            ready;
    logic [rxcrc_pkg::IDX_W-1:0]     buffer_index;
    logic [rxcrc_pkg::QID_W-1:0]     queue_id;
    logic [rxcrc_pkg::LEN_W-1:0]     frame_len_in;
    logic                            error_bit;
    logic                            gen_bit;
    logic                            buffer_kind;
    logic                            head_update_asked;

    modport source (
        output valid, buffer_index, queue_id, frame_len_in, error_bit, gen_bit,
               buffer_kind, head_update_asked,
        input  ready
    );

    modport sink (
        input  valid, buffer_index, queue_id, frame_len_in, error_bit, gen_bit,
               buffer_kind, head_update_asked,
        output ready
    );
endinterface

@@ sv/rxcrc_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxcrc_res_if
// Valid/ready channel carrying one consumer result.
// ----------------------------------------------------------------------------
interface rxcrc_res_if;
    logic                            valid;
    logic                            ready;
    logic                            stale;
    logic [1:0]                      drop_reason;
    logic                            ring_select;
    logic [rxcrc_pkg::IDX_W-1:0]     slot_out;
    logic [rxcrc_pkg::LEN_W-1:0]     frame_len_out;
    logic                            head_write;
    logic                            head_bank;
    logic [rxcrc_pkg::QID_W-1:0]     head_queue;
    logic [rxcrc_pkg::IDX_W-1:0]     head_value;
    logic [rxcrc_pkg::IDX_W-1:0]     refill_slot;
    logic                            refill_gen;

    modport source (
        output valid, stale, drop_reason, ring_select, slot_out, frame_len_out,
               head_write, head_bank, head_queue, head_value, refill_slot, refill_gen,
        input  ready
    );

    modport sink (
        input  valid, stale, drop_reason, ring_select, slot_out, frame_len_out,
               head_write, head_bank, head_queue, head_value, refill_slot, refill_gen,
        output ready
    );
endinterface

@@ sv/rx_completion_ring_consumer_top.sv @@
`timescale 1ns / 1ps
// Path from input transfer to result valid: input register, then result register.
// Throughput: 1 descriptor per cycle unless the result channel stalls; the classify logic
// between the two registers handles one item per clock and the pointers of a consumed
// descriptor update in that same cycle. Reset (synchronous, active low): completion pointer 0,
// expected generation 1, refill pointer 0, refill generation 0, minimum frame length 60, both stages empty.
// ----------------------------------------------------------------------------
// rx_completion_ring_consumer_top
// Receive completion ring consumer: generation check, drop decision, head
// register update and ring-0 refill slot per descriptor.
// ----------------------------------------------------------------------------
`include "rx_completion_ring_consumer_top_macros.svh"

module rx_completion_ring_consumer_top #(
    parameter int RING_DEPTH  = 128,
    parameter int COMP_DEPTH  = 256,
    parameter int QUEUE_COUNT = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [rxcrc_pkg::LEN_W-1:0] i_cfg_wr_data,
    rxcrc_comp_if.sink                  i_comp,
    rxcrc_res_if.source                 o_res
);

    rxcrc_pkg::t_comp_item          w_in_item;
    rxcrc_pkg::t_comp_item          w_stage_item;
    rxcrc_pkg::t_ptr_state          w_ptr;
    rxcrc_pkg::t_result             w_result;
    rxcrc_pkg::t_result             r_out;
    logic                           w_stage_vld;
    logic                           w_stale;
    logic                           w_adv;
    logic                           r_out_vld;
    logic                           n_out_vld;
    logic [rxcrc_pkg::LEN_W-1:0]    r_min_len;

    // Gather the input channel into one item
    assign w_in_item.buffer_index      = i_comp.buffer_index;
    assign w_in_item.queue_id          = i_comp.queue_id;
    assign w_in_item.frame_len_in      = i_comp.frame_len_in;
    assign w_in_item.error_bit         = i_comp.error_bit;
    assign w_in_item.gen_bit           = i_comp.gen_bit;
    assign w_in_item.buffer_kind       = i_comp.buffer_kind;
    assign w_in_item.head_update_asked = i_comp.head_update_asked;

    // Minimum frame length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= rxcrc_pkg::MIN_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_min_len <= i_cfg_wr_data;
        end
    end

    // Move the held item into the result register when it is free or draining
    assign w_adv = w_stage_vld && (!r_out_vld || o_res.ready);

    rxcrc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_comp.valid),
        .i_item    (w_in_item),
        .o_ready   (i_comp.ready),
        .i_advance (w_adv),
        .o_valid   (w_stage_vld),
        .o_item    (w_stage_item)
    );

    rxcrc_ptr_track #(
        .RING_DEPTH (RING_DEPTH),
        .COMP_DEPTH (COMP_DEPTH)
    ) u_ptr_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_consume (w_adv && !w_stale),
        .o_state   (w_ptr)
    );

    rxcrc_classify #(
        .RING_DEPTH  (RING_DEPTH),
        .QUEUE_COUNT (QUEUE_COUNT)
    ) u_classify (
        .i_item    (w_stage_item),
        .i_ptr     (w_ptr),
        .i_min_len (r_min_len),
        .o_stale   (w_stale),
        .o_result  (w_result)
    );

    // Result register valid: set on advance, clear once taken
    always_comb begin
        n_out_vld = r_out_vld;
        if (w_adv) begin
            n_out_vld = 1'b1;
        end else if (o_res.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    // Drive the result channel
    assign o_res.valid         = r_out_vld;
    assign o_res.stale         = r_out.stale;
    assign o_res.drop_reason   = r_out.drop_reason;
    assign o_res.ring_select   = r_out.ring_select;
    assign o_res.slot_out      = r_out.slot_out;
    assign o_res.frame_len_out = r_out.frame_len_out;
    assign o_res.head_write    = r_out.head_write;
    assign o_res.head_bank     = r_out.head_bank;
    assign o_res.head_queue    = r_out.head_queue;
    assign o_res.head_value    = r_out.head_value;
    assign o_res.refill_slot   = r_out.refill_slot;
    assign o_res.refill_gen    = r_out.refill_gen;

    // A stale descriptor leaves the pointers untouched
    `RXCRC_ASSERT_NEXT(a_stale_holds_ptr, i_clk, i_rst_n, w_adv && w_stale, $stable(w_ptr))

    // A consumed descriptor always moves the refill position
    `RXCRC_ASSERT_NEXT(a_refill_steps, i_clk, i_rst_n, w_adv && !w_stale, (w_ptr.refill_slot != $past(w_ptr.refill_slot)) || (w_ptr.refill_gen != $past(w_ptr.refill_gen)))

    // A stale result carries nothing but its flag
    `RXCRC_ASSERT_SAME(a_stale_clean, i_clk, i_rst_n, r_out_vld && r_out.stale, (r_out.drop_reason == rxcrc_pkg::DROP_NONE) && !r_out.head_write && (r_out.refill_slot == '0) && !r_out.refill_gen && (r_out.frame_len_out == '0))

    // Only a delivered frame reports a length
    `RXCRC_ASSERT_SAME(a_len_on_deliver, i_clk, i_rst_n, r_out_vld && (r_out.frame_len_out != '0), !r_out.stale && (r_out.drop_reason == rxcrc_pkg::DROP_NONE))

endmodule

@@ sv/rxcrc_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxcrc_in_stage
// Input register: captures one completion descriptor per transfer.
// ----------------------------------------------------------------------------
module rxcrc_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  rxcrc_pkg::t_comp_item i_item,
    output logic                  o_ready,
    input  logic                  i_advance,
    output logic                  o_valid,
    output rxcrc_pkg::t_comp_item o_item
);

    logic                  r_vld;
    logic                  n_vld;
    rxcrc_pkg::t_comp_item r_item;

    // Take a new item when empty or when the held one moves on
    assign o_ready = !r_vld || i_advance;

    always_comb begin
        n_vld = r_vld;
        if (o_ready) begin
            n_vld = i_valid;
        end
    end

    // Hold valid under reset control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Load payload on transfer
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

@@ sv/rxcrc_ptr_track.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxcrc_ptr_track
// Completion pointer with expected generation, refill pointer with its
// generation; both advance once per consumed descriptor.
// ----------------------------------------------------------------------------
module rxcrc_ptr_track #(
    parameter int RING_DEPTH = 128,
    parameter int COMP_DEPTH = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_consume,
    output rxcrc_pkg::t_ptr_state o_state
);

    localparam int CW = $clog2(COMP_DEPTH);
    localparam int RW = $clog2(RING_DEPTH);
    localparam int RX = (RW > rxcrc_pkg::IDX_W) ? RW : rxcrc_pkg::IDX_W;

    logic [CW-1:0] r_comp_ptr;
    logic [CW-1:0] n_comp_ptr;
    logic          r_exp_gen;
    logic          n_exp_gen;
    logic [RW-1:0] r_refill_ptr;
    logic [RW-1:0] n_refill_ptr;
    logic          r_refill_gen;
    logic          n_refill_gen;
    logic [RX-1:0] w_refill_ext;

    // Advance both pointers, toggle generation on wrap
    always_comb begin
        n_comp_ptr   = r_comp_ptr;
        n_exp_gen    = r_exp_gen;
        n_refill_ptr = r_refill_ptr;
        n_refill_gen = r_refill_gen;
        if (i_consume) begin
            if (r_comp_ptr == CW'(COMP_DEPTH - 1)) begin
                n_comp_ptr = '0;
                n_exp_gen  = !r_exp_gen;
            end else begin
                n_comp_ptr = r_comp_ptr + CW'(1);
            end
            if (r_refill_ptr == RW'(RING_DEPTH - 1)) begin
                n_refill_ptr = '0;
                n_refill_gen = !r_refill_gen;
            end else begin
                n_refill_ptr = r_refill_ptr + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp_ptr   <= '0;
            r_exp_gen    <= 1'b1;
            r_refill_ptr <= '0;
            r_refill_gen <= 1'b0;
        end else begin
            r_comp_ptr   <= n_comp_ptr;
            r_exp_gen    <= n_exp_gen;
            r_refill_ptr <= n_refill_ptr;
            r_refill_gen <= n_refill_gen;
        end
    end

    // Mask the refill pointer to the slot field width
    assign w_refill_ext        = RX'(r_refill_ptr);
    assign o_state.exp_gen     = r_exp_gen;
    assign o_state.refill_slot = w_refill_ext[rxcrc_pkg::IDX_W-1:0];
    assign o_state.refill_gen  = r_refill_gen;

endmodule

@@ sv/rxcrc_classify.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rxcrc_classify
// Generation check, ring select, drop decision, head update and refill slot for one
// registered completion descriptor.
// ----------------------------------------------------------------------------
module rxcrc_classify #(
    parameter int RING_DEPTH  = 128,
    parameter int QUEUE_COUNT = 1
) (
    input  rxcrc_pkg::t_comp_item          i_item,
    input  rxcrc_pkg::t_ptr_state          i_ptr,
    input  logic [rxcrc_pkg::LEN_W-1:0]    i_min_len,
    output logic                           o_stale,
    output rxcrc_pkg::t_result             o_result
);

    localparam int TBL_N = 1 << rxcrc_pkg::IDX_W;

    logic [rxcrc_pkg::IDX_W-1:0] w_head_tbl [0:TBL_N];
    logic [rxcrc_pkg::IDX_W:0]   w_idx_inc;
    logic                        w_ring;
    rxcrc_pkg::t_drop_reason     w_reason;

    // Constant table of (index + 1) mod ring depth
    genvar g;
    for (g = 0; g <= TBL_N; g++) begin : g_head_tbl
        localparam int HV = g % RING_DEPTH;
        assign w_head_tbl[g] = HV[rxcrc_pkg::IDX_W-1:0];
    end

    assign w_idx_inc = {1'b0, i_item.buffer_index} + (rxcrc_pkg::IDX_W + 1)'(1);
    assign o_stale   = (i_item.gen_bit != i_ptr.exp_gen);
    assign w_ring    = (i_item.queue_id >= rxcrc_pkg::QID_W'(QUEUE_COUNT));

    // Drop priority: body buffer, then error, then short frame
    always_comb begin
        if (i_item.buffer_kind) begin
            w_reason = rxcrc_pkg::DROP_BODY;
        end else if (i_item.error_bit) begin
            w_reason = rxcrc_pkg::DROP_ERROR;
        end else if (i_item.frame_len_in < i_min_len) begin
            w_reason = rxcrc_pkg::DROP_SHORT;
        end else begin
            w_reason = rxcrc_pkg::DROP_NONE;
        end
    end

    // Build the result; a stale item reports only the stale flag
    always_comb begin
        o_result             = '0;
        o_result.drop_reason = rxcrc_pkg::DROP_NONE;
        if (o_stale) begin
            o_result.stale = 1'b1;
        end else begin
            o_result.drop_reason = w_reason;
            o_result.ring_select = w_ring;
            o_result.slot_out    = i_item.buffer_index;
            if (w_reason == rxcrc_pkg::DROP_NONE) begin
                o_result.frame_len_out = i_item.frame_len_in;
            end
            if (i_item.head_update_asked) begin
                o_result.head_write = 1'b1;
                o_result.head_bank  = w_ring;
                o_result.head_queue = w_ring
                    ? (i_item.queue_id - rxcrc_pkg::QID_W'(QUEUE_COUNT))
                    : i_item.queue_id;
                o_result.head_value = w_head_tbl[w_idx_inc];
            end
            o_result.refill_slot = i_ptr.refill_slot;
            o_result.refill_gen  = i_ptr.refill_gen;
        end
    end

endmodule
